// ===== rtl/jve_pkg.sv =====
// Package for the joint velocity estimator: widths, status and register codes,
// state entry and divider status types. No dependencies.
package jve_pkg;

    localparam int JOINT_COUNT = 14;
    localparam int JOINT_W     = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

    localparam int INDEX_W    = 4;
    localparam int ANGLE_W    = 12;
    localparam int TIME_W     = 32;
    localparam int VEL_W      = 31;
    localparam int STATUS_W   = 2;
    localparam int WEIGHT_W   = 9;
    localparam int MIN_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int DIVIDEND_W = 30;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
    localparam int ACC_W      = 40;

    localparam logic [INDEX_W:0]        JOINT_LIMIT = (INDEX_W + 1)'(JOINT_COUNT);
    localparam logic [DIVIDEND_W-1:0]   RATE_Q8     = DIVIDEND_W'(256000);
    localparam logic [WEIGHT_W-1:0]     WEIGHT_ONE  = WEIGHT_W'(256);
    localparam logic signed [ACC_W-1:0] ACC_LIMIT   = ACC_W'(1048320000);
    localparam logic signed [ACC_W-1:0] ACC_ROUND   = ACC_W'(128);

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_WEIGHT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL  = CFG_IDX_W'(1);

    localparam logic [WEIGHT_W-1:0] FILTER_WEIGHT_RESET = WEIGHT_W'(51);
    localparam logic [MIN_W-1:0]    MIN_INTERVAL_RESET  = MIN_W'(1);

    typedef enum logic [STATUS_W-1:0] {
        ST_UPDATED = 2'd0,
        ST_FIRST   = 2'd1,
        ST_SHORT   = 2'd2,
        ST_BAD     = 2'd3
    } t_status;

    typedef struct packed {
        logic [ANGLE_W-1:0]      angle;
        logic [TIME_W-1:0]       time_ms;
        logic signed [VEL_W-1:0] vel;
    } t_entry;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== rtl/jve_state_ram.sv =====
// Per-joint state memory: last angle, last time and filtered velocity.
// One write port, one read port with registered data. Uses jve_pkg.
module jve_state_ram (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [jve_pkg::JOINT_W-1:0] i_rd_addr,
    output jve_pkg::t_entry       o_rd_data,
    input  logic                  i_wr_en,
    input  logic [jve_pkg::JOINT_W-1:0] i_wr_addr,
    input  jve_pkg::t_entry       i_wr_data
);
    import jve_pkg::*;

    t_entry r_mem [JOINT_COUNT];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/jve_divider.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Divides the scaled angle delta by the time gap. Uses jve_pkg.
module jve_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [jve_pkg::DIVIDEND_W-1:0] i_dividend,
    input  logic [jve_pkg::TIME_W-1:0]    i_divisor,
    output jve_pkg::t_div_stat            o_stat,
    output logic [jve_pkg::DIVIDEND_W-1:0] o_quotient
);
    import jve_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0]     r_rem;
    logic [TIME_W-1:0]     r_div;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [TIME_W:0]   trial;
    logic [TIME_W-1:0] n_rem;
    logic              n_bit;

    always_comb begin
        trial = {r_rem, r_quo[DIVIDEND_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = TIME_W'(trial - {1'b0, r_div});
            n_bit = 1'b1;
        end else begin
            n_rem = trial[TIME_W-1:0];
            n_bit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIVIDEND_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIVIDEND_W-2:0], n_bit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

// ===== rtl/joint_velocity_estimator_top.sv =====
// Top level of the joint velocity estimator: control sequencer, seen flags,
// configuration registers and filter. Uses jve_pkg, jve_state_ram, jve_divider.
//
// One sample is worked on at a time. A sample that updates the velocity passes
// through one state read, one scaling multiply, the 30-step serial divider (one
// quotient bit per cycle) and two filter multiplies before its result is loaded;
// a first sample or a short gap skips the divider and the filter, and a bad index
// also skips the state read. A finished result waits in the output register
// while the next sample is taken; a new result waits in S_FIN until that register
// is free. All joint state is invalidated at reset by clearing the per-joint seen
// flags; no clearing pass is needed.
module joint_velocity_estimator_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [jve_pkg::INDEX_W-1:0]        i_joint_index,
    input  logic [jve_pkg::ANGLE_W-1:0]        i_angle_counts,
    input  logic [jve_pkg::TIME_W-1:0]         i_time_ms,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [jve_pkg::VEL_W-1:0]   o_velocity,
    output logic [jve_pkg::STATUS_W-1:0]       o_status,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [jve_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [jve_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import jve_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LOOK = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_FLT1 = 7'b0010000,
        S_FLT2 = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    logic [JOINT_COUNT-1:0]  r_seen;
    logic                    r_out_valid;
    logic [WEIGHT_W-1:0]     r_filter_weight;
    logic [MIN_W-1:0]        r_min_interval;

    logic [JOINT_W-1:0]      r_idx;
    logic [ANGLE_W-1:0]      r_angle;
    logic [TIME_W-1:0]       r_time;
    t_status                 r_status;
    logic                    r_neg;
    logic [ANGLE_W-1:0]      r_mag;
    logic [TIME_W-1:0]       r_gap;
    logic signed [VEL_W-1:0] r_old_vel;
    logic signed [VEL_W-1:0] r_raw;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [VEL_W-1:0] r_velocity;
    t_status                 r_out_status;

    logic                    in_beat;
    logic                    bad_in;
    logic                    fin_load;
    t_entry                  rd_data;
    t_entry                  wr_data;
    logic                    wr_en;
    logic [TIME_W-1:0]       gap;
    logic                    short_gap;
    logic signed [ANGLE_W:0] delta;
    logic [DIVIDEND_W-1:0]   dividend;
    t_div_stat               div_stat;
    logic [DIVIDEND_W-1:0]   quotient;
    logic signed [VEL_W-1:0] n_raw;
    logic [WEIGHT_W-1:0]     w_eff;
    logic signed [WEIGHT_W:0] w_s;
    logic signed [WEIGHT_W:0] cw_s;
    logic signed [ACC_W-1:0] shifted;
    logic signed [VEL_W-1:0] new_vel;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_beat     = i_valid && o_ready;
    assign bad_in      = ({1'b0, i_joint_index} >= JOINT_LIMIT);
    assign fin_load    = (r_state == S_FIN) && (!r_out_valid || i_ready);

    assign gap       = r_time - rd_data.time_ms;
    assign short_gap = (gap == '0) || (gap < TIME_W'(r_min_interval));
    assign delta     = $signed({1'b0, r_angle}) - $signed({1'b0, rd_data.angle});
    assign dividend  = DIVIDEND_W'(r_mag) * RATE_Q8;
    assign n_raw     = r_neg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});

    assign w_eff = (r_filter_weight > WEIGHT_ONE) ? WEIGHT_ONE : r_filter_weight;
    assign w_s   = $signed({1'b0, w_eff});
    assign cw_s  = $signed({1'b0, WEIGHT_ONE}) - w_s;

    always_comb begin
        shifted = r_acc >>> 8;
        if (shifted > ACC_LIMIT) begin
            new_vel = VEL_W'(ACC_LIMIT);
        end else if (shifted < -ACC_LIMIT) begin
            new_vel = VEL_W'(-ACC_LIMIT);
        end else begin
            new_vel = VEL_W'(shifted);
        end
    end

    always_comb begin
        wr_en         = fin_load && (r_status == ST_UPDATED || r_status == ST_FIRST);
        wr_data.angle = r_angle;
        wr_data.time_ms = r_time;
        wr_data.vel   = (r_status == ST_UPDATED) ? new_vel : '0;
    end

    jve_state_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (in_beat && !bad_in),
        .i_rd_addr (i_joint_index[JOINT_W-1:0]),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (wr_data)
    );

    jve_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_MUL),
        .i_dividend (dividend),
        .i_divisor  (r_gap),
        .o_stat     (div_stat),
        .o_quotient (quotient)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = bad_in ? S_FIN : S_LOOK;
                end
            end
            S_LOOK: begin
                if (!r_seen[r_idx] || short_gap) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_DIV;
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_FLT1;
                end
            end
            S_FLT1: n_state = S_FLT2;
            S_FLT2: n_state = S_FIN;
            S_FIN: begin
                if (fin_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_seen          <= '0;
            r_out_valid     <= 1'b0;
            r_filter_weight <= FILTER_WEIGHT_RESET;
            r_min_interval  <= MIN_INTERVAL_RESET;
        end else begin
            r_state <= n_state;
            if (fin_load && r_status == ST_FIRST) begin
                r_seen[r_idx] <= 1'b1;
            end
            if (fin_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FILTER_WEIGHT: r_filter_weight <= i_cfg_data;
                    CFG_MIN_INTERVAL:  r_min_interval  <= i_cfg_data[MIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx    <= i_joint_index[JOINT_W-1:0];
                r_angle  <= i_angle_counts;
                r_time   <= i_time_ms;
                r_status <= ST_BAD;
            end
            S_LOOK: begin
                r_gap     <= gap;
                r_old_vel <= rd_data.vel;
                r_neg     <= delta[ANGLE_W];
                r_mag     <= ANGLE_W'(delta[ANGLE_W] ? -delta : delta);
                if (!r_seen[r_idx]) begin
                    r_status <= ST_FIRST;
                end else if (short_gap) begin
                    r_status <= ST_SHORT;
                end else begin
                    r_status <= ST_UPDATED;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    r_raw <= n_raw;
                end
            end
            S_FLT1: r_acc <= ACC_W'(w_s) * ACC_W'(r_raw);
            S_FLT2: r_acc <= r_acc + ACC_W'(cw_s) * ACC_W'(r_old_vel) + ACC_ROUND;
            S_FIN: begin
                if (fin_load) begin
                    r_out_status <= r_status;
                    r_velocity   <= (r_status == ST_UPDATED) ? new_vel : '0;
                end
            end
            default: ;
        endcase
    end

    assign o_valid    = r_out_valid;
    assign o_velocity = r_velocity;
    assign o_status   = r_out_status;

`ifndef SYNTHESIS
    a_zero_unless_updated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_UPDATED) |-> (o_velocity == '0))
        else $error("velocity nonzero on a result that did not update");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_div_busy_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> (r_state == S_DIV))
        else $error("divider running outside the divide state");

    a_bad_skips_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && bad_in) |=> (r_state == S_FIN))
        else $error("bad index did not go straight to the result");

    a_update_keeps_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_load && r_status == ST_UPDATED) |=> (r_seen == $past(r_seen)))
        else $error("seen flags changed on a velocity update");
`endif

endmodule
